// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/core/lclip_pkg.sv =====
// ----------------------------------------------------------------------------
// lclip_pkg
// Types and constants shared by the line clipper.
// ----------------------------------------------------------------------------
`default_nettype none
package lclip_pkg;
	localparam logic [3:0] OC_LEFT   = 4'b0001;
	localparam logic [3:0] OC_RIGHT  = 4'b0010;
	localparam logic [3:0] OC_BOTTOM = 4'b0100;
	localparam logic [3:0] OC_TOP    = 4'b1000;
	localparam int PASS_LIMIT = 16;

	localparam logic [1:0] REG_LEFT   = 2'd0;
	localparam logic [1:0] REG_BOTTOM = 2'd1;
	localparam logic [1:0] REG_RIGHT  = 2'd2;
	localparam logic [1:0] REG_TOP    = 2'd3;

	typedef struct packed {
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
	} seg_t;

	typedef struct packed {
		logic               accepted;
		logic signed [15:0] clip_start_x;
		logic signed [15:0] clip_start_y;
		logic signed [15:0] clip_end_x;
		logic signed [15:0] clip_end_y;
	} res_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] bottom;
		logic signed [15:0] right;
		logic signed [15:0] top;
	} win_t;

	// classified segment handed from front to back
	typedef struct packed {
		seg_t       seg;
		logic [3:0] c0;
		logic [3:0] c1;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_MUL,
		ST_DIV,
		ST_APPLY,
		ST_OUT
	} bk_state_t;

	function automatic logic [3:0] outcode(logic signed [15:0] x, logic signed [15:0] y,
			win_t w);
		logic [3:0] c;
		c = 4'b0000;
		if (x < w.left)
			c = c | OC_LEFT;
		else if (x > w.right)
			c = c | OC_RIGHT;
		if (y < w.bottom)
			c = c | OC_BOTTOM;
		else if (y > w.top)
			c = c | OC_TOP;
		return c;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/lclip_if.sv =====
// ----------------------------------------------------------------------------
// lclip_seg_if / lclip_res_if
// Valid/ready channels for segments and clip results.
// ----------------------------------------------------------------------------
`default_nettype none
interface lclip_seg_if;
	logic             valid;
	logic             ready;
	lclip_pkg::seg_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lclip_res_if;
	logic             valid;
	logic             ready;
	lclip_pkg::res_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/lclip_front.sv =====
// ----------------------------------------------------------------------------
// lclip_front
// Accepts segments, computes both outcodes and queues them (2 entries).
// ----------------------------------------------------------------------------
`default_nettype none
module lclip_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lclip_pkg::win_t   win,
	input  wire lclip_pkg::seg_t   in_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output lclip_pkg::job_t        job,
	output logic                   job_valid,
	input  wire logic              job_ready
);
	lclip_pkg::job_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;
	lclip_pkg::job_t new_job;

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;
	assign job       = mem_q[rd_ptr_q];

	always_comb begin
		new_job.seg = in_data;
		new_job.c0  = lclip_pkg::outcode(in_data.start_x, in_data.start_y, win);
		new_job.c1  = lclip_pkg::outcode(in_data.end_x, in_data.end_y, win);
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= new_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/lclip_div.sv =====
// ----------------------------------------------------------------------------
// lclip_div
// Signed 34/17 restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none
module lclip_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [33:0] num,
	input  wire logic signed [16:0] den,
	output logic                    done,
	output logic signed [33:0]      quo
);
	logic [33:0] rem_q;
	logic [33:0] q_q;
	logic [16:0] d_q;
	logic        neg_q;
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [34:0] trial;
	logic [33:0] shifted;

	assign shifted = {rem_q[32:0], q_q[33]};
	assign trial   = {1'b0, shifted} - {18'd0, d_q};
	assign done    = busy_q && (cnt_q == 6'd0);
	assign quo     = neg_q ? -$signed(q_q) : $signed(q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd34;
		end else if (busy_q && cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 34'd0;
			q_q   <= num[33] ? 34'(-num) : 34'(num);
			d_q   <= den[16] ? 17'(-den) : 17'(den);
			neg_q <= (num[33] ^ den[16]) && (den != 17'sd0);
		end else if (busy_q && cnt_q != 6'd0) begin
			if (d_q == 17'd0) begin
				q_q   <= 34'd0;
				rem_q <= 34'd0;
			end else if (!trial[34]) begin
				rem_q <= trial[33:0];
				q_q   <= {q_q[32:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[32:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/lclip_back.sv =====
// ----------------------------------------------------------------------------
// lclip_back
// Runs the clip passes for one queued segment and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
module lclip_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lclip_pkg::win_t   win,
	input  wire lclip_pkg::job_t   job,
	input  wire logic              job_valid,
	output logic                   job_ready,
	output lclip_pkg::res_t        res,
	output logic                   res_valid,
	input  wire logic              res_ready
);
	lclip_pkg::bk_state_t state_q, state_d;
	logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
	logic [3:0]         c0_q, c1_q;
	logic [4:0]         pass_q;
	logic               acc_q;
	logic [3:0]         c;
	logic               sel0;
	logic               vert;
	logic signed [16:0] span, delta, den;
	logic signed [15:0] base_q, edge_q;
	logic signed [16:0] span_q, delta_q, den_q;
	logic signed [33:0] prod;
	logic               div_start;
	logic               div_done;
	logic signed [33:0] quo;
	logic signed [15:0] nv;
	logic signed [15:0] nx, ny;
	logic               decide_acc, decide_rej;

	assign c    = (c0_q != 4'd0) ? c0_q : c1_q;
	assign sel0 = (c0_q != 4'd0);
	assign vert = (c & (lclip_pkg::OC_TOP | lclip_pkg::OC_BOTTOM)) != 4'd0;
	assign decide_acc = (c0_q | c1_q) == 4'd0;
	assign decide_rej = ((c0_q & c1_q) != 4'd0) || (pass_q == 5'(lclip_pkg::PASS_LIMIT));

	always_comb begin
		if (vert) begin
			span = 17'(x1_q) - 17'(x0_q);
			den  = 17'(y1_q) - 17'(y0_q);
		end else begin
			span = 17'(y1_q) - 17'(y0_q);
			den  = 17'(x1_q) - 17'(x0_q);
		end
		if ((c & lclip_pkg::OC_TOP) != 4'd0)
			delta = 17'(win.top) - 17'(y0_q);
		else if ((c & lclip_pkg::OC_BOTTOM) != 4'd0)
			delta = 17'(win.bottom) - 17'(y0_q);
		else if ((c & lclip_pkg::OC_RIGHT) != 4'd0)
			delta = 17'(win.right) - 17'(x0_q);
		else
			delta = 17'(win.left) - 17'(x0_q);
	end

	// product is taken by the divider when it starts
	assign prod = span_q * delta_q;

	lclip_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign nv = 16'(base_q + 16'(quo));
	always_comb begin
		if (vert) begin
			nx = nv;
			ny = edge_q;
		end else begin
			nx = edge_q;
			ny = nv;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lclip_pkg::ST_IDLE:   if (job_valid) state_d = lclip_pkg::ST_DECIDE;
			lclip_pkg::ST_DECIDE: begin
				if (decide_acc || decide_rej)
					state_d = lclip_pkg::ST_OUT;
				else
					state_d = lclip_pkg::ST_MUL;
			end
			lclip_pkg::ST_MUL:    state_d = lclip_pkg::ST_DIV;
			lclip_pkg::ST_DIV:    if (div_done) state_d = lclip_pkg::ST_APPLY;
			lclip_pkg::ST_APPLY:  state_d = lclip_pkg::ST_DECIDE;
			lclip_pkg::ST_OUT:    if (res_ready) state_d = lclip_pkg::ST_IDLE;
			default:              state_d = lclip_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (state_q == lclip_pkg::ST_IDLE);
		res_valid = (state_q == lclip_pkg::ST_OUT);
		div_start = (state_q == lclip_pkg::ST_MUL);
	end

	assign res = '{accepted: acc_q, clip_start_x: x0_q, clip_start_y: y0_q,
		clip_end_x: x1_q, clip_end_y: y1_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lclip_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			lclip_pkg::ST_IDLE: begin
				x0_q   <= job.seg.start_x;
				y0_q   <= job.seg.start_y;
				x1_q   <= job.seg.end_x;
				y1_q   <= job.seg.end_y;
				c0_q   <= job.c0;
				c1_q   <= job.c1;
				pass_q <= 5'd0;
			end
			lclip_pkg::ST_DECIDE: begin
				acc_q   <= decide_acc;
				span_q  <= span;
				delta_q <= delta;
				den_q   <= den;
				base_q  <= vert ? x0_q : y0_q;
				if ((c & lclip_pkg::OC_TOP) != 4'd0)
					edge_q <= win.top;
				else if ((c & lclip_pkg::OC_BOTTOM) != 4'd0)
					edge_q <= win.bottom;
				else if ((c & lclip_pkg::OC_RIGHT) != 4'd0)
					edge_q <= win.right;
				else
					edge_q <= win.left;
			end
			lclip_pkg::ST_MUL: ;
			lclip_pkg::ST_APPLY: begin
				pass_q <= pass_q + 5'd1;
				if (sel0) begin
					x0_q <= nx;
					y0_q <= ny;
					c0_q <= lclip_pkg::outcode(nx, ny, win);
				end else begin
					x1_q <= nx;
					y1_q <= ny;
					c1_q <= lclip_pkg::outcode(nx, ny, win);
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/core/line_clip_outcode_unit.sv =====
// ----------------------------------------------------------------------------
// line_clip_outcode_unit
// Cohen-Sutherland segment clipper against a programmable window.
// ----------------------------------------------------------------------------
// A segment decided at once passes from the queue through the idle, decide
// and output states of the clip engine. Each clip pass runs decide, multiply,
// the bit-serial divider that computes the edge crossing, and update; a
// proper window needs at most four passes per segment, and an inverted
// window can run to the 16-pass limit.
// A two-entry queue after the outcode stage lets new segments enter while
// one is clipped; the result is held until taken.
`default_nettype none
module line_clip_outcode_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	lclip_seg_if.sink        seg,
	lclip_res_if.source      res
);
	lclip_pkg::win_t win_q;
	lclip_pkg::job_t job;
	logic            job_valid;
	logic            job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lclip_pkg::REG_LEFT:   win_q.left   <= cfg_data;
				lclip_pkg::REG_BOTTOM: win_q.bottom <= cfg_data;
				lclip_pkg::REG_RIGHT:  win_q.right  <= cfg_data;
				lclip_pkg::REG_TOP:    win_q.top    <= cfg_data;
				default: ;
			endcase
		end
	end

	lclip_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win_q),
		.in_data   (seg.data),
		.in_valid  (seg.valid),
		.in_ready  (seg.ready),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready)
	);

	lclip_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win_q),
		.job       (job),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.res       (res.data),
		.res_valid (res.valid),
		.res_ready (res.ready)
	);
endmodule
`default_nettype wire

// ===== rtl/core/lclip_checker.sv =====
// ----------------------------------------------------------------------------
// lclip_checker
// Port-level checks on the line clipper.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lclip_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            res_valid,
	input wire logic            res_ready,
	input wire lclip_pkg::res_t res_data
);
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)
	`ASSERT_NEXT(a_res_stable, clk, arst_n, res_valid && !res_ready, $stable(res_data))
	`ASSERT_NEXT(a_one_result, clk, arst_n, res_valid && res_ready, !res_valid)
endmodule

bind line_clip_outcode_unit lclip_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
`default_nettype wire

// ===== test/line_clip_checker.sv =====
// ----------------------------------------------------------------------------
// line_clip_checker
// Watches the segment and result channels and the window register port of
// the line clipper. Predicts the clipped segment for every accepted request
// and compares it field by field with the result that comes back, in order.
// ----------------------------------------------------------------------------
module line_clip_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	lclip_seg_if        seg,
	lclip_res_if        res,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lclip_pkg::*;

	localparam int MAX_MOVES = 16;

	win_t win;
	res_t clip_queue[$];

	function automatic logic [3:0] region_code(int x, int y, win_t w);
		logic [3:0] c;
		c = 4'b0000;
		if (x < int'(w.left))
			c |= OC_LEFT;
		else if (x > int'(w.right))
			c |= OC_RIGHT;
		if (y < int'(w.bottom))
			c |= OC_BOTTOM;
		else if (y > int'(w.top))
			c |= OC_TOP;
		return c;
	endfunction

	// base + span * (edge - from) / den, truncated toward zero, wrapped to 16 bits
	function automatic int edge_cross(int base, int span, int edge_val, int from, int den);
		longint prod;
		longint quo;
		logic signed [15:0] wrapped;
		prod = longint'(span) * longint'(edge_val - from);
		quo = (den != 0) ? prod / longint'(den) : 64'sd0;
		wrapped = 16'(longint'(base) + quo);
		return int'(wrapped);
	endfunction

	function automatic res_t clip_segment(seg_t s, win_t w);
		int x0, y0, x1, y1, x, y;
		logic [3:0] c0, c1, c;
		logic acc;
		res_t r;
		x0 = int'(s.start_x);
		y0 = int'(s.start_y);
		x1 = int'(s.end_x);
		y1 = int'(s.end_y);
		c0 = region_code(x0, y0, w);
		c1 = region_code(x1, y1, w);
		acc = 1'b0;
		for (int n = 0; n <= MAX_MOVES; n++) begin
			if ((c0 | c1) == 4'b0000) begin
				acc = 1'b1;
				break;
			end
			if ((c0 & c1) != 4'b0000 || n == MAX_MOVES)
				break;
			c = (c0 != 4'b0000) ? c0 : c1;
			if (c & OC_TOP) begin
				x = edge_cross(x0, x1 - x0, int'(w.top), y0, y1 - y0);
				y = int'(w.top);
			end else if (c & OC_BOTTOM) begin
				x = edge_cross(x0, x1 - x0, int'(w.bottom), y0, y1 - y0);
				y = int'(w.bottom);
			end else if (c & OC_RIGHT) begin
				y = edge_cross(y0, y1 - y0, int'(w.right), x0, x1 - x0);
				x = int'(w.right);
			end else begin
				y = edge_cross(y0, y1 - y0, int'(w.left), x0, x1 - x0);
				x = int'(w.left);
			end
			if (c0 != 4'b0000) begin
				x0 = x;
				y0 = y;
				c0 = region_code(x0, y0, w);
			end else begin
				x1 = x;
				y1 = y;
				c1 = region_code(x1, y1, w);
			end
		end
		r.accepted = acc;
		r.clip_start_x = 16'(x0);
		r.clip_start_y = 16'(y0);
		r.clip_end_x = 16'(x1);
		r.clip_end_y = 16'(y1);
		return r;
	endfunction

	assign pending = clip_queue.size();

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		res_t got;
		if (!arst_n) begin
			win <= '0;
			errors <= 0;
			clip_queue.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LEFT: win.left <= cfg_data;
					REG_BOTTOM: win.bottom <= cfg_data;
					REG_RIGHT: win.right <= cfg_data;
					REG_TOP: win.top <= cfg_data;
					default: ;
				endcase
			end
			if (seg.valid && seg.ready)
				clip_queue.push_back(clip_segment(seg.data, win));
			if (res.valid && res.ready) begin
				got = res.data;
				if (clip_queue.size() == 0) begin
					$display("%0t: unexpected result %p", $realtime, got);
					errors <= errors + 1;
				end else begin
					exp_r = clip_queue.pop_front();
					if (got.accepted !== exp_r.accepted ||
							got.clip_start_x !== exp_r.clip_start_x ||
							got.clip_start_y !== exp_r.clip_start_y ||
							got.clip_end_x !== exp_r.clip_end_x ||
							got.clip_end_y !== exp_r.clip_end_y) begin
						$display({"%0t: mismatch expected %0d (%0d,%0d)-(%0d,%0d)",
							" got %0d (%0d,%0d)-(%0d,%0d)"},
							$realtime, exp_r.accepted, exp_r.clip_start_x,
							exp_r.clip_start_y, exp_r.clip_end_x, exp_r.clip_end_y,
							got.accepted, got.clip_start_x, got.clip_start_y,
							got.clip_end_x, got.clip_end_y);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// ===== test/line_clip_outcode_unit_tb.sv =====
// ----------------------------------------------------------------------------
// line_clip_outcode_unit_tb
// Drives segments through the clipper under a series of clip windows (reset,
// proper, full range, single point, inverted, random) with random gaps and
// result stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module line_clip_outcode_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lclip_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          errors;
	int          pending;
	int          stall_run;
	win_t        cur_win;

	lclip_seg_if seg ();
	lclip_res_if res ();

	line_clip_outcode_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.seg(seg),
		.res(res)
	);

	line_clip_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.seg(seg),
		.res(res),
		.errors(errors),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#60ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// result stalls: runs of ready or not ready, mostly short
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_run <= 0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			res.ready <= ($urandom_range(0, 3) != 0);
			stall_run <= pick_gap();
		end
	end

	function automatic logic [15:0] near_coord(logic signed [15:0] lo, logic signed [15:0] hi);
		int a, b, r;
		a = int'(lo) - 200;
		b = int'(hi) + 200;
		if (a > b) begin
			r = a;
			a = b;
			b = r;
		end
		r = $urandom_range(0, 99);
		if (r < 12)
			return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
		else if (r < 40)
			return 16'($urandom);
		return 16'(a + int'($urandom_range(0, b - a)));
	endfunction

	function automatic seg_t rand_segment();
		seg_t s;
		s.start_x = near_coord(cur_win.left, cur_win.right);
		s.start_y = near_coord(cur_win.bottom, cur_win.top);
		s.end_x = near_coord(cur_win.left, cur_win.right);
		s.end_y = near_coord(cur_win.bottom, cur_win.top);
		return s;
	endfunction

	task automatic send_segment(seg_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			seg.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seg.valid <= 1'b1;
		seg.data <= s;
		@(posedge clk);
		while (!seg.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		seg.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic set_window(int l, int b, int r, int t);
		drain();
		cur_win = '{left: 16'(l), bottom: 16'(b), right: 16'(r), top: 16'(t)};
		cfg_we <= 1'b1;
		cfg_index <= REG_LEFT;
		cfg_data <= 16'(l);
		@(negedge clk);
		cfg_index <= REG_BOTTOM;
		cfg_data <= 16'(b);
		@(negedge clk);
		cfg_index <= REG_RIGHT;
		cfg_data <= 16'(r);
		@(negedge clk);
		cfg_index <= REG_TOP;
		cfg_data <= 16'(t);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_segment(rand_segment());
	endtask

	task automatic seg_xy(int x0, int y0, int x1, int y1);
		send_segment('{start_x: 16'(x0), start_y: 16'(y0), end_x: 16'(x1), end_y: 16'(y1)});
	endtask

	initial begin
		int l, b, r, t;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LEFT;
		cfg_data = '0;
		seg.valid = 1'b0;
		seg.data = '0;
		cur_win = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset window is the single point at the origin
		seg_xy(0, 0, 0, 0);
		seg_xy(-32768, -32768, 32767, 32767);
		seg_xy(-5, 3, 5, -3);
		run_random(80);

		set_window(-1000, -800, 1200, 900);
		seg_xy(0, 0, 100, 100);
		seg_xy(-2000, 0, 2000, 0);
		seg_xy(0, -2000, 0, 2000);
		seg_xy(-2000, -2000, -1500, 2000);
		seg_xy(1300, 1000, 1500, 950);
		seg_xy(-2000, -1500, 2000, 1500);
		seg_xy(0, 0, 0, 5000);
		seg_xy(0, 0, 0, -5000);
		seg_xy(0, 0, 5000, 0);
		seg_xy(0, 0, -5000, 0);
		seg_xy(-32768, -32768, 32767, 32767);
		seg_xy(32767, -32768, -32768, 32767);
		seg_xy(-1000, -800, 1200, 900);
		seg_xy(-1100, 950, -900, 1000);
		seg_xy(-1500, 500, 0, 2000);
		seg_xy(32767, 32767, 32767, 32767);
		drain();
		run_random(400);

		set_window(-32768, -32768, 32767, 32767);
		seg_xy(-32768, 32767, 32767, -32768);
		run_random(120);

		set_window(5, 5, 5, 5);
		seg_xy(0, 0, 10, 10);
		seg_xy(5, -32768, 5, 32767);
		run_random(120);

		set_window(32767, 32767, 32767, 32767);
		run_random(60);

		set_window(100, 100, -100, -100);
		seg_xy(0, 0, 0, 0);
		seg_xy(-32768, -32768, 32767, 32767);
		run_random(100);

		set_window(-32768, -32768, -32768, -32768);
		run_random(60);

		for (int p = 0; p < 8; p++) begin
			l = $urandom_range(0, 65535) - 32768;
			r = $urandom_range(0, 65535) - 32768;
			b = $urandom_range(0, 65535) - 32768;
			t = $urandom_range(0, 65535) - 32768;
			if (p < 6 && l > r) begin
				int s;
				s = l;
				l = r;
				r = s;
			end
			if (p < 6 && b > t) begin
				int s;
				s = b;
				b = t;
				t = s;
			end
			set_window(l, b, r, t);
			run_random(120);
		end

		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
